[src/ufsm_pkg.sv]
`default_nettype none

package ufsm_pkg;

  // fixed field widths of the stream payload
  localparam int unsigned MODE_W = 2;
  localparam int unsigned NODE_W = 10;
  localparam int unsigned SIZE_W = 11;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  // request kinds
  localparam logic [MODE_W-1:0] MODE_JOIN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_COMP,
    ST_MERGE_BIG,
    ST_MERGE_SMALL,
    ST_OUT
  } state_t;

  // which root search is running
  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_A_FINAL
  } phase_t;

endpackage : ufsm_pkg

`default_nettype wire

[src/ufsm_ram.sv]
`default_nettype none

module ufsm_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, new data on a same-address collision
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule : ufsm_ram

`default_nettype wire

[src/union_find_set_merger.sv]
`default_nettype none

// channel  | dir | tdata (low bit first)                        | tuser
// ---------+-----+----------------------------------------------+-----------
// in_      | in  | node_a[9:0], node_b[19:10], zero [23:20]     | mode[1:0]
// out_     | out | same_set[0], merged[1], root[11:2],          | -
//          |     | set_size[22:12], zero [23]                   |
//
// one request at a time; a root walk reads one link a cycle and rewrites the
// path; three walks, plus two merge writes on a join of two different roots
// after reset and on a clear request a clearing pass rewrites every entry with
// in_tready low
// a held result stalls the next request in front of the result register

module union_find_set_merger #(
  parameter int unsigned NODES = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,

  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [ufsm_pkg::IN_TDATA_W-1:0]      in_tdata,   // node_a, node_b
  input  wire logic [ufsm_pkg::MODE_W-1:0]          in_tuser,   // mode

  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic      [ufsm_pkg::OUT_TDATA_W-1:0]     out_tdata   // same_set, merged,
                                                                // root, set_size
);

  localparam int unsigned IW = $clog2(NODES);  // node index width
  localparam int unsigned EW = IW + 1;         // entry: root flag + index or size-1

  // entry layout: [IW] root flag, [IW-1:0] parent index or set size minus one

  ufsm_pkg::state_t state_r, state_nxt;
  ufsm_pkg::phase_t phase_r, phase_nxt;

  logic [ufsm_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [IW-1:0] node_a_r, node_a_nxt;
  logic [IW-1:0] node_b_r, node_b_nxt;
  logic [IW-1:0] cur_r, cur_nxt;       // walk pointer, also compression pointer
  logic [IW-1:0] start_r, start_nxt;   // first node of the running walk
  logic [IW-1:0] root_r, root_nxt;
  logic [IW-1:0] rsize_r, rsize_nxt;
  logic [IW-1:0] ra_r, ra_nxt;
  logic [IW-1:0] sa_r, sa_nxt;
  logic [IW-1:0] rb_r, rb_nxt;
  logic [IW-1:0] sb_r, sb_nxt;
  logic [IW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          clr_report_r, clr_report_nxt;

  logic                        res_same_r, res_same_nxt;
  logic                        res_merged_r, res_merged_nxt;
  logic [ufsm_pkg::NODE_W-1:0] res_root_r, res_root_nxt;
  logic [ufsm_pkg::SIZE_W-1:0] res_size_r, res_size_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [ufsm_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // entry store port
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [ufsm_pkg::NODE_W-1:0] in_node_a;
  logic [ufsm_pkg::NODE_W-1:0] in_node_b;
  logic                        in_xfer;
  logic                        in_range;

  // find completion
  logic          find_done;
  logic [IW-1:0] found_root;
  logic [IW-1:0] found_size;

  // merge choice: the larger set keeps its root, node_a's root on a tie
  logic          b_bigger;
  logic [IW-1:0] big_root;
  logic [IW-1:0] small_root;

  assign in_node_a = in_tdata[ufsm_pkg::NODE_W-1:0];
  assign in_node_b = in_tdata[2*ufsm_pkg::NODE_W-1:ufsm_pkg::NODE_W];
  assign in_tready = (state_r == ufsm_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign in_range  = (32'(in_node_a) < NODES) && (32'(in_node_b) < NODES);

  assign b_bigger   = (sa_r < sb_r);
  assign big_root   = b_bigger ? rb_r : ra_r;
  assign small_root = b_bigger ? ra_r : rb_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  ufsm_ram #(
    .WIDTH (EW),
    .DEPTH (NODES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ufsm_pkg::ST_CLEAR;
      clr_cnt_r    <= '0;
      clr_report_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_report_r <= clr_report_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r      <= phase_nxt;
    mode_r       <= mode_nxt;
    node_a_r     <= node_a_nxt;
    node_b_r     <= node_b_nxt;
    cur_r        <= cur_nxt;
    start_r      <= start_nxt;
    root_r       <= root_nxt;
    rsize_r      <= rsize_nxt;
    ra_r         <= ra_nxt;
    sa_r         <= sa_nxt;
    rb_r         <= rb_nxt;
    sb_r         <= sb_nxt;
    res_same_r   <= res_same_nxt;
    res_merged_r <= res_merged_nxt;
    res_root_r   <= res_root_nxt;
    res_size_r   <= res_size_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    mode_nxt       = mode_r;
    node_a_nxt     = node_a_r;
    node_b_nxt     = node_b_r;
    cur_nxt        = cur_r;
    start_nxt      = start_r;
    root_nxt       = root_r;
    rsize_nxt      = rsize_r;
    ra_nxt         = ra_r;
    sa_nxt         = sa_r;
    rb_nxt         = rb_r;
    sb_nxt         = sb_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_report_nxt = clr_report_r;
    res_same_nxt   = res_same_r;
    res_merged_nxt = res_merged_r;
    res_root_nxt   = res_root_r;
    res_size_nxt   = res_size_r;
    out_data_nxt   = out_data_r;

    // the result register empties on its own transfer
    out_valid_nxt  = out_valid_r && !out_tready;

    ram_we     = 1'b0;
    ram_waddr  = cur_r;
    ram_wdata  = {1'b0, root_r};
    ram_raddr  = cur_r;

    find_done  = 1'b0;
    found_root = root_r;
    found_size = rsize_r;

    case (state_r)
      ufsm_pkg::ST_CLEAR: begin
        // every entry back to a singleton root
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = {1'b1, {IW{1'b0}}};
        clr_cnt_nxt = clr_cnt_r + IW'(1);
        if (clr_cnt_r == IW'(NODES - 1)) begin
          clr_cnt_nxt = '0;
          if (clr_report_r) begin
            clr_report_nxt = 1'b0;
            state_nxt      = ufsm_pkg::ST_OUT;
          end else begin
            state_nxt = ufsm_pkg::ST_IDLE;
          end
        end
      end

      ufsm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          mode_nxt       = in_tuser;
          node_a_nxt     = IW'(in_node_a);
          node_b_nxt     = IW'(in_node_b);
          res_same_nxt   = 1'b0;
          res_merged_nxt = 1'b0;
          res_root_nxt   = '0;
          res_size_nxt   = '0;
          if (in_tuser == ufsm_pkg::MODE_CLEAR) begin
            clr_cnt_nxt    = '0;
            clr_report_nxt = 1'b1;
            state_nxt      = ufsm_pkg::ST_CLEAR;
          end else if ((in_tuser != ufsm_pkg::MODE_JOIN &&
                        in_tuser != ufsm_pkg::MODE_QUERY) || !in_range) begin
            state_nxt = ufsm_pkg::ST_OUT;
          end else begin
            phase_nxt = ufsm_pkg::PH_A;
            cur_nxt   = IW'(in_node_a);
            start_nxt = IW'(in_node_a);
            ram_raddr = IW'(in_node_a);
            state_nxt = ufsm_pkg::ST_WALK;
          end
        end
      end

      ufsm_pkg::ST_WALK: begin
        // ram_rdata holds the entry of cur_r
        if (ram_rdata[IW]) begin
          root_nxt  = cur_r;
          rsize_nxt = ram_rdata[IW-1:0];
          if (start_r == cur_r) begin
            find_done  = 1'b1;
            found_root = cur_r;
            found_size = ram_rdata[IW-1:0];
          end else begin
            // second pass: point the whole path straight at the root
            cur_nxt   = start_r;
            ram_raddr = start_r;
            state_nxt = ufsm_pkg::ST_COMP;
          end
        end else begin
          cur_nxt   = ram_rdata[IW-1:0];
          ram_raddr = ram_rdata[IW-1:0];
        end
      end

      ufsm_pkg::ST_COMP: begin
        ram_we    = 1'b1;
        ram_waddr = cur_r;
        ram_wdata = {1'b0, root_r};
        if (ram_rdata[IW-1:0] == root_r) begin
          find_done = 1'b1;
        end else begin
          cur_nxt   = ram_rdata[IW-1:0];
          ram_raddr = ram_rdata[IW-1:0];
        end
      end

      ufsm_pkg::ST_MERGE_BIG: begin
        ram_we    = 1'b1;
        ram_waddr = big_root;
        ram_wdata = {1'b1, IW'(sa_r + sb_r + IW'(1))};
        state_nxt = ufsm_pkg::ST_MERGE_SMALL;
      end

      ufsm_pkg::ST_MERGE_SMALL: begin
        ram_we         = 1'b1;
        ram_waddr      = small_root;
        ram_wdata      = {1'b0, big_root};
        res_merged_nxt = 1'b1;
        phase_nxt      = ufsm_pkg::PH_A_FINAL;
        cur_nxt        = node_a_r;
        start_nxt      = node_a_r;
        ram_raddr      = node_a_r;
        state_nxt      = ufsm_pkg::ST_WALK;
      end

      ufsm_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = ufsm_pkg::OUT_TDATA_W'({res_size_r, res_root_r,
                                                  res_merged_r, res_same_r});
          state_nxt     = ufsm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ufsm_pkg::ST_IDLE;
      end
    endcase

    // a root walk finished: pick the next step by phase
    if (find_done) begin
      case (phase_r)
        ufsm_pkg::PH_A: begin
          ra_nxt    = found_root;
          sa_nxt    = found_size;
          phase_nxt = ufsm_pkg::PH_B;
          cur_nxt   = node_b_r;
          start_nxt = node_b_r;
          ram_raddr = node_b_r;
          state_nxt = ufsm_pkg::ST_WALK;
        end
        ufsm_pkg::PH_B: begin
          rb_nxt       = found_root;
          sb_nxt       = found_size;
          res_same_nxt = (found_root == ra_r);
          if (mode_r == ufsm_pkg::MODE_JOIN && found_root != ra_r) begin
            state_nxt = ufsm_pkg::ST_MERGE_BIG;
          end else begin
            phase_nxt = ufsm_pkg::PH_A_FINAL;
            cur_nxt   = node_a_r;
            start_nxt = node_a_r;
            ram_raddr = node_a_r;
            state_nxt = ufsm_pkg::ST_WALK;
          end
        end
        ufsm_pkg::PH_A_FINAL: begin
          res_root_nxt = ufsm_pkg::NODE_W'(found_root);
          res_size_nxt = ufsm_pkg::SIZE_W'({1'b0, found_size} + EW'(1));
          state_nxt    = ufsm_pkg::ST_OUT;
        end
        default: begin
          state_nxt = ufsm_pkg::ST_OUT;
        end
      endcase
    end
  end

  // the store is never touched between requests
  a_idle_no_write : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ufsm_pkg::ST_IDLE) |-> !ram_we)
    else $error("entry store written while idle");

  // path compression never turns the root itself into a link
  a_comp_not_root : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ufsm_pkg::ST_COMP) |-> (ram_waddr != root_r))
    else $error("compression overwrote the root entry");

  // a merge only follows a join over two different roots
  a_merge_cause : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ufsm_pkg::ST_MERGE_BIG) |->
      (mode_r == ufsm_pkg::MODE_JOIN) && (ra_r != rb_r) && !res_same_r)
    else $error("merge started without two distinct roots");

  // a reported merge never claims the nodes already shared a set
  a_merge_vs_same : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[0] && out_data_r[1]))
    else $error("result marks both same_set and merged");

  // out of reset the clearing pass runs before any transfer is taken
  a_reset_clears : assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> (state_r == ufsm_pkg::ST_CLEAR) && !in_tready)
    else $error("input ready before the clearing pass");

endmodule : union_find_set_merger

`default_nettype wire
